// ===== hdl/bpr_pkg.sv =====
// shared types and constants for the bitmap pixel row packer
// used by the front pipeline, the item queue and the byte sequencer
package bpr_pkg;

    // configuration port shape and register indexes
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_BITCOUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BITS  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_SOURCE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_BITS     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_BITS   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_BITS    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_BITS   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PADDING  = 4'd7;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // one classified pixel as the byte sequencer sees it
    typedef struct packed {
        logic        indexed;
        logic [3:0]  bc;       // index width in indexed mode
        logic [7:0]  idx;      // index masked to bc bits
        logic [2:0]  nbytes;   // bytes of word in direct mode
        logic [31:0] word;     // packed direct pixel
        logic        row_end;
        logic [1:0]  pad;
    } bpr_item_t;

endpackage

// ===== hdl/bpr_front.sv =====
// front part: configuration registers, pixel classification and the
// five-stage channel rescale and field packing pipeline; uses bpr_pkg
module bpr_front #(
    parameter int MAX_CHANNEL_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [31:0]                    sample_first,
    input  logic [31:0]                    sample_green,
    input  logic [31:0]                    sample_blue,
    input  logic [31:0]                    sample_alpha,
    input  logic                           row_end,
    output logic                           q_push,
    output bpr_pkg::bpr_item_t             q_item,
    input  logic                           q_full
);
    import bpr_pkg::*;

    localparam logic [5:0] MAXC   = 6'(MAX_CHANNEL_BITS);
    localparam int         STAGES = 5;

    typedef struct packed {
        bpr_item_t        item;
        logic [3:0][31:0] lane;   // red, green, blue, alpha
        logic [3:0][5:0]  to;
        logic [5:0]       from;
        logic [2:0][6:0]  sh;     // placement of red, green, blue
    } stage_t;

    function automatic logic [5:0] clamp_bits(input logic [5:0] b);
        return (b > MAXC) ? MAXC : b;
    endfunction

    logic [5:0] out_bitcount_reg;
    logic [5:0] source_bits_reg;
    logic       gray_source_reg;
    logic [5:0] red_bits_reg;
    logic [5:0] green_bits_reg;
    logic [5:0] blue_bits_reg;
    logic [5:0] alpha_bits_reg;
    logic [1:0] row_padding_reg;

    stage_t st_reg  [STAGES];
    stage_t st_next [STAGES];
    logic   vld_reg [STAGES];

    logic       advance;
    logic       accept;
    logic [5:0] sb_c, rb_c, gb_c, bb_c, ab_c;
    logic       indexed;
    logic [7:0] idx_mask;
    logic [31:0] t0, t1, t2, t3, t4;

    // configuration writes, always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_bitcount_reg <= 6'd24;
            source_bits_reg  <= 6'd8;
            gray_source_reg  <= 1'b0;
            red_bits_reg     <= 6'd8;
            green_bits_reg   <= 6'd8;
            blue_bits_reg    <= 6'd8;
            alpha_bits_reg   <= 6'd0;
            row_padding_reg  <= 2'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OUT_BITCOUNT: out_bitcount_reg <= cfg_data[5:0];
                CFG_SOURCE_BITS:  source_bits_reg  <= cfg_data[5:0];
                CFG_GRAY_SOURCE:  gray_source_reg  <= cfg_data[0];
                CFG_RED_BITS:     red_bits_reg     <= cfg_data[5:0];
                CFG_GREEN_BITS:   green_bits_reg   <= cfg_data[5:0];
                CFG_BLUE_BITS:    blue_bits_reg    <= cfg_data[5:0];
                CFG_ALPHA_BITS:   alpha_bits_reg   <= cfg_data[5:0];
                CFG_ROW_PADDING:  row_padding_reg  <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // pipeline moves as a whole while its last stage can drain
    assign advance = !vld_reg[STAGES-1] || !q_full;
    assign full    = !advance;
    assign accept  = push && advance;
    assign q_push  = vld_reg[STAGES-1] && !q_full;
    assign q_item  = st_reg[STAGES-1].item;

    // classification and clamped widths
    assign sb_c    = clamp_bits(source_bits_reg);
    assign rb_c    = clamp_bits(red_bits_reg);
    assign gb_c    = clamp_bits(green_bits_reg);
    assign bb_c    = clamp_bits(blue_bits_reg);
    assign ab_c    = clamp_bits(alpha_bits_reg);
    assign indexed = (out_bitcount_reg == 6'd1) || (out_bitcount_reg == 6'd2) ||
                     (out_bitcount_reg == 6'd4) || (out_bitcount_reg == 6'd8);

    always_comb
    begin
        unique case (out_bitcount_reg)
            6'd1:    idx_mask = 8'h01;
            6'd2:    idx_mask = 8'h03;
            6'd4:    idx_mask = 8'h0f;
            default: idx_mask = 8'hff;
        endcase
    end

    always_comb
    begin
        // stage 1: take the pixel, align each sample at the top of the word
        st_next[0].item.indexed = indexed;
        st_next[0].item.bc      = out_bitcount_reg[3:0];
        st_next[0].item.idx     = sample_first[7:0] & idx_mask;
        st_next[0].item.nbytes  = (out_bitcount_reg[5:3] > 3'd4) ? 3'd4
                                                                 : out_bitcount_reg[5:3];
        st_next[0].item.word    = '0;
        st_next[0].item.row_end = row_end;
        st_next[0].item.pad     = row_padding_reg;
        st_next[0].lane[0] = sample_first << (6'd32 - sb_c);
        st_next[0].lane[1] = (gray_source_reg ? sample_first : sample_green)
                             << (6'd32 - sb_c);
        st_next[0].lane[2] = (gray_source_reg ? sample_first : sample_blue)
                             << (6'd32 - sb_c);
        st_next[0].lane[3] = sample_alpha << (6'd32 - sb_c);
        st_next[0].to[0]   = rb_c;
        st_next[0].to[1]   = gb_c;
        st_next[0].to[2]   = bb_c;
        st_next[0].to[3]   = ab_c;
        st_next[0].from    = sb_c;
        st_next[0].sh[0]   = 7'(gb_c) + 7'(bb_c) + 7'(ab_c);
        st_next[0].sh[1]   = 7'(bb_c) + 7'(ab_c);
        st_next[0].sh[2]   = 7'(ab_c);

        // stage 2 and 3: repeat the source bits downwards by doubling
        st_next[1] = st_reg[0];
        st_next[2] = st_reg[1];
        st_next[3] = st_reg[2];
        st_next[4] = st_reg[3];
        t0 = '0;
        t1 = '0;
        t2 = '0;
        t3 = '0;
        t4 = '0;
        for (int k = 0; k < 4; k++)
        begin
            t0 = st_reg[0].lane[k] | (st_reg[0].lane[k] >> st_reg[0].from);
            st_next[1].lane[k] = t0 | (t0 >> {st_reg[0].from, 1'b0});
            t1 = st_reg[1].lane[k] | (st_reg[1].lane[k] >> {st_reg[1].from, 2'b0});
            st_next[2].lane[k] = t1 | (t1 >> {st_reg[1].from, 3'b0});
            // stage 4: last doubling, then keep the top field bits
            t2 = st_reg[2].lane[k] | (st_reg[2].lane[k] >> {st_reg[2].from, 4'b0});
            st_next[3].lane[k] = t2 >> (6'd32 - st_reg[2].to[k]);
        end

        // stage 5: place the fields, red highest
        t3 = (st_reg[3].lane[0] << st_reg[3].sh[0]) |
             (st_reg[3].lane[1] << st_reg[3].sh[1]);
        t4 = (st_reg[3].lane[2] << st_reg[3].sh[2]) | st_reg[3].lane[3];
        st_next[4].item.word = t3 | t4;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= accept;
            for (int i = 1; i < STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

endmodule

// ===== hdl/bpr_queue.sv =====
// short queue of classified pixels between the front and the back
// uses the item type and depth constants of bpr_pkg
module bpr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_push,
    input  bpr_pkg::bpr_item_t q_item,
    output logic               q_full,
    input  logic               q_pop,
    output bpr_pkg::bpr_item_t q_head,
    output logic               q_empty
);
    import bpr_pkg::*;

    bpr_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_head  = entry_reg[rd_ptr_reg];
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_item;
        end
    end

endmodule

// ===== hdl/bpr_back.sv =====
// back part: index accumulator, per-pixel byte run and the result register
// takes classified pixels from bpr_queue; uses bpr_pkg
module bpr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  bpr_pkg::bpr_item_t q_head,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic [7:0]         out_byte,
    output logic               last_of_run
);
    import bpr_pkg::*;

    localparam int RUN_BYTES = 7;

    logic [7:0]             accum_reg, accum_next;
    logic [3:0]             used_reg, used_next;
    logic [RUN_BYTES*8-1:0] run_buf_reg, run_buf_next;
    logic [2:0]             run_cnt_reg, run_cnt_next;
    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_last_reg;

    logic                   emit_go, load;
    logic [4:0]             sum;
    logic                   pre_flush, full_byte, end_flush;
    logic [7:0]             pf_byte, a1, ins_a, a3, ef_byte;
    logic [3:0]             u1, u2, u3;
    logic [3:0][7:0]        base;
    logic [2:0]             n0;
    logic [RUN_BYTES*8-1:0] new_buf;
    logic [2:0]             new_cnt;

    // one byte a request into the result register
    assign emit_go = (run_cnt_reg != 3'd0) && (!out_valid_reg || pop);
    assign load    = !q_empty &&
                     ((run_cnt_reg == 3'd0) || ((run_cnt_reg == 3'd1) && emit_go));
    assign q_pop   = load;

    // bytes caused by the pixel at the queue head
    always_comb
    begin
        sum       = {1'b0, used_reg} + {1'b0, q_head.bc};
        pre_flush = q_head.indexed && (sum > 5'd8);
        pf_byte   = accum_reg << (4'd8 - used_reg);
        a1        = pre_flush ? 8'd0 : accum_reg;
        u1        = pre_flush ? 4'd0 : used_reg;
        ins_a     = (a1 << q_head.bc) | q_head.idx;
        u2        = u1 + q_head.bc;
        full_byte = q_head.indexed && (u2 == 4'd8);

        if (!q_head.indexed || full_byte)
        begin
            a3 = 8'd0;
            u3 = 4'd0;
        end
        else
        begin
            a3 = ins_a;
            u3 = u2;
        end

        end_flush = q_head.row_end && (u3 != 4'd0);
        ef_byte   = a3 << (4'd8 - u3);

        if (q_head.indexed)
        begin
            base[0] = pre_flush ? pf_byte : ins_a;
            base[1] = (pre_flush && full_byte) ? ins_a : 8'd0;
            base[2] = 8'd0;
            base[3] = 8'd0;
            n0      = {2'b00, pre_flush} + {2'b00, full_byte};
        end
        else
        begin
            base = q_head.word;
            n0   = q_head.nbytes;
        end

        // compact: pixel bytes, then the row flush, padding stays zero
        new_buf = '0;
        for (int i = 0; i < RUN_BYTES; i++)
        begin
            if (i < 4 && 3'(i) < n0)
            begin
                new_buf[i*8 +: 8] = base[i[1:0]];
            end
            else if (end_flush && 3'(i) == n0)
            begin
                new_buf[i*8 +: 8] = ef_byte;
            end
        end
        new_cnt = n0 + {2'b00, end_flush} + (q_head.row_end ? {1'b0, q_head.pad} : 3'd0);
    end

    // accumulator and run update
    always_comb
    begin
        accum_next   = accum_reg;
        used_next    = used_reg;
        run_buf_next = run_buf_reg;
        run_cnt_next = run_cnt_reg;
        if (load)
        begin
            accum_next   = q_head.row_end ? 8'd0 : a3;
            used_next    = q_head.row_end ? 4'd0 : u3;
            run_buf_next = new_buf;
            run_cnt_next = new_cnt;
        end
        else if (emit_go)
        begin
            run_buf_next = run_buf_reg >> 8;
            run_cnt_next = run_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg     <= 8'd0;
            used_reg      <= 4'd0;
            run_cnt_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            accum_reg   <= accum_next;
            used_reg    <= used_next;
            run_cnt_reg <= run_cnt_next;
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // run bytes and result payload
    always_ff @(posedge clk)
    begin
        run_buf_reg <= run_buf_next;
        if (emit_go)
        begin
            out_byte_reg <= run_buf_reg[7:0];
            out_last_reg <= (run_cnt_reg == 3'd1);
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

endmodule

// ===== hdl/bitmap_pixel_row_packer.sv =====
// Bitmap pixel row packer: takes one pixel per request and delivers bitmap pixel-data
// bytes, one per cycle while the receiver keeps popping, on a queue-style result port.
// A five-stage front pipeline rescales and packs the channels and accepts a pixel every
// cycle while the four-entry item queue has room; a byte sequencer behind the queue
// emits each pixel's bytes through a single result register. Each pixel causes
// out_bitcount/8 bytes (at most 4) in direct mode, 0 to 2 in indexed mode (two when an
// index that does not fit forces out the partial byte and then completes a byte), plus
// the row flush byte and row_padding zero bytes on the last pixel of a row; the
// one-byte-per-cycle result register sets the pixel throughput. Configuration is to be
// written through the cfg port by the user only while the block is idle; the block
// itself does not enforce this.
// top level; instantiates bpr_front, bpr_queue and bpr_back, uses bpr_pkg
module bitmap_pixel_row_packer #(
    parameter int MAX_CHANNEL_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [31:0]                    sample_first,
    input  logic [31:0]                    sample_green,
    input  logic [31:0]                    sample_blue,
    input  logic [31:0]                    sample_alpha,
    input  logic                           row_end,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     out_byte,
    output logic                           last_of_run
);
    import bpr_pkg::*;

    bpr_item_t q_item, q_head;
    logic      q_push, q_full, q_pop, q_empty;

    // classify and pack
    bpr_front #(
        .MAX_CHANNEL_BITS(MAX_CHANNEL_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .sample_first (sample_first),
        .sample_green (sample_green),
        .sample_blue  (sample_blue),
        .sample_alpha (sample_alpha),
        .row_end      (row_end),
        .q_push       (q_push),
        .q_item       (q_item),
        .q_full       (q_full)
    );

    // decoupling queue
    bpr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_item  (q_item),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_empty (q_empty)
    );

    // byte sequencing and result register
    bpr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_head      (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

// ===== hdl/bpr_checker.sv =====
// port-level checks for the bitmap pixel row packer
// bound to the top level; sees only its ports
module bpr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // a waiting result holds until it is taken
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_of_run)))
        else $error("waiting result changed before pop");

    // leaving reset: nothing queued and room for a pixel
    a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (empty && !full))
        else $error("block not clear after reset");

    // configuration writes are never stalled
    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration request stalled");

    // the result side is still empty just after leaving reset
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |=> empty)
        else $error("result appeared without a pixel");

endmodule

bind bitmap_pixel_row_packer bpr_checker u_bpr_checker (.*);

// ===== bench/bitmap_pixel_row_packer_tb.sv =====
// self-checking bench for the bitmap pixel row packer: pixels in, pixel-data bytes out
// predicts every byte from its own copy of the registers and the index accumulator
// depends on bpr_pkg and the bitmap_pixel_row_packer top level
module bitmap_pixel_row_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpr_pkg::*;

    localparam int CHAN_MAX      = 32;
    localparam int RAND_ITEMS    = 320;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_CYCLES  = 250;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_MAX    = 10;

    // index outside the register map, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd15;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] green;
        logic [31:0] blue;
        logic [31:0] alpha;
        logic        row_end;
    } pixel_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } exp_byte_t;

    // raw register bytes as written, the block keeps only the low bits
    typedef struct packed {
        logic [7:0] bitcount;
        logic [7:0] src_bits;
        logic [7:0] gray;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] pad;
    } fmt_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [31:0]           sample_first = '0;
    logic [31:0]           sample_green = '0;
    logic [31:0]           sample_blue = '0;
    logic [31:0]           sample_alpha = '0;
    logic                  row_end = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [7:0]            out_byte;
    logic                  last_of_run;

    // predictor copy of the registers and the index accumulator
    logic [5:0] cur_bitcount = 6'd24;
    logic [5:0] cur_src_bits = 6'd8;
    logic       cur_gray = 1'b0;
    logic [5:0] cur_red = 6'd8;
    logic [5:0] cur_green = 6'd8;
    logic [5:0] cur_blue = 6'd8;
    logic [5:0] cur_alpha = 6'd0;
    logic [1:0] cur_pad = 2'd0;
    logic [7:0] acc_byte = 8'd0;
    logic [3:0] acc_fill = 4'd0;

    pixel_t    pixel_q[$];
    exp_byte_t expected_bytes_q[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_stall_req = 0;
    int rx_stall_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    bitmap_pixel_row_packer #(
        .MAX_CHANNEL_BITS(CHAN_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .push(push),
        .full(full),
        .sample_first(sample_first),
        .sample_green(sample_green),
        .sample_blue(sample_blue),
        .sample_alpha(sample_alpha),
        .row_end(row_end),
        .empty(empty),
        .pop(pop),
        .out_byte(out_byte),
        .last_of_run(last_of_run)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [63:0] width_mask(int unsigned bits);
        return (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    endfunction

    function automatic int unsigned clamp_width(logic [5:0] w);
        return (w > CHAN_MAX) ? CHAN_MAX : w;
    endfunction

    function automatic bit is_indexed(logic [5:0] bc);
        return (bc == 6'd1 || bc == 6'd2 || bc == 6'd4 || bc == 6'd8);
    endfunction

    // truncate when narrowing, repeat the source bits when widening
    function automatic logic [63:0] rescale_channel(logic [63:0] v, int unsigned from_w,
                                                    int unsigned to_w);
        logic [63:0] r;
        int unsigned left;
        v = v & width_mask(from_w);
        if (from_w >= to_w)
            return (v >> (from_w - to_w)) & width_mask(to_w);
        if (from_w == 0)
            return 64'd0;
        left = to_w - from_w;
        r = v << left;
        while (left > 0)
        begin
            if (left >= from_w)
            begin
                r = r | (v << (left - from_w));
                left = left - from_w;
            end
            else
            begin
                r = r | (v >> (from_w - left));
                left = 0;
            end
        end
        return r & width_mask(to_w);
    endfunction

    function automatic logic [63:0] place_field(logic [63:0] v, int unsigned shift);
        return (shift < 64) ? (v << shift) : 64'd0;
    endfunction

    // bytes that one accepted pixel causes, appended to the expected store
    function automatic void pack_pixel(pixel_t p);
        logic [7:0]  run_q[$];
        int unsigned bc, idx, fill, accv, sb, rb, gb, bb, ab, nbytes;
        logic [63:0] r, g, b, word;
        bc   = cur_bitcount;
        fill = acc_fill;
        accv = acc_byte;
        if (is_indexed(cur_bitcount))
        begin
            idx = p.first & ((32'd1 << bc) - 32'd1);
            // index does not fit in what is left of the byte
            if (fill + bc > 8)
            begin
                run_q.push_back(8'((accv << (8 - fill)) & 'hff));
                accv = 0;
                fill = 0;
            end
            accv = ((accv << bc) | idx) & 'hff;
            fill = fill + bc;
            if (fill == 8)
            begin
                run_q.push_back(8'(accv));
                accv = 0;
                fill = 0;
            end
        end
        else
        begin
            sb = clamp_width(cur_src_bits);
            rb = clamp_width(cur_red);
            gb = clamp_width(cur_green);
            bb = clamp_width(cur_blue);
            ab = clamp_width(cur_alpha);
            r  = {32'd0, p.first};
            g  = cur_gray ? r : {32'd0, p.green};
            b  = cur_gray ? r : {32'd0, p.blue};
            // a direct pixel drops any partial index byte
            accv = 0;
            fill = 0;
            word = place_field(rescale_channel(r, sb, rb), gb + bb + ab)
                 | place_field(rescale_channel(g, sb, gb), bb + ab)
                 | place_field(rescale_channel(b, sb, bb), ab);
            if (ab != 0)
                word = word | rescale_channel({32'd0, p.alpha}, sb, ab);
            nbytes = bc >> 3;
            if (nbytes > 4)
                nbytes = 4;
            for (int i = 0; i < nbytes; i++)
                run_q.push_back(word[8*i +: 8]);
        end
        // row end: flush left-aligned partial byte, then zero padding
        if (p.row_end)
        begin
            if (fill != 0)
            begin
                run_q.push_back(8'((accv << (8 - fill)) & 'hff));
                accv = 0;
                fill = 0;
            end
            for (int i = 0; i < cur_pad; i++)
                run_q.push_back(8'd0);
        end
        acc_byte = accv[7:0];
        acc_fill = fill[3:0];
        foreach (run_q[i])
            expected_bytes_q.push_back('{data: run_q[i], is_last: (i == run_q.size() - 1)});
    endfunction

    function automatic void record_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        case (idx)
            CFG_OUT_BITCOUNT: cur_bitcount = data[5:0];
            CFG_SOURCE_BITS:  cur_src_bits = data[5:0];
            CFG_GRAY_SOURCE:  cur_gray     = data[0];
            CFG_RED_BITS:     cur_red      = data[5:0];
            CFG_GREEN_BITS:   cur_green    = data[5:0];
            CFG_BLUE_BITS:    cur_blue     = data[5:0];
            CFG_ALPHA_BITS:   cur_alpha    = data[5:0];
            CFG_ROW_PADDING:  cur_pad      = data[1:0];
            default: ;
        endcase
    endfunction

    function automatic void note_error(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] error: %s", $realtime, msg);
    endfunction

    function automatic void check_byte(logic [7:0] got, logic got_last);
        exp_byte_t want;
        if (expected_bytes_q.size() == 0)
        begin
            note_error($sformatf("byte %02h last %b with nothing expected", got, got_last));
            return;
        end
        want = expected_bytes_q.pop_front();
        if (got !== want.data)
            note_error($sformatf("out_byte expected %02h actual %02h", want.data, got));
        if (got_last !== want.is_last)
            note_error($sformatf("last_of_run expected %b actual %b (byte %02h)",
                                 want.is_last, got_last, want.data));
    endfunction

    // sample all accepted requests at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                record_cfg(cfg_index, cfg_data);
            if (push && !full)
            begin
                pack_pixel('{sample_first, sample_green, sample_blue, sample_alpha, row_end});
                void'(pixel_q.pop_front());
            end
            if (pop && !empty)
                check_byte(out_byte, last_of_run);
        end
    end

    // pixel driver, offers the oldest pending pixel
    always @(negedge clk)
    begin
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
        begin
            push         <= 1'b1;
            sample_first <= pixel_q[0].first;
            sample_green <= pixel_q[0].green;
            sample_blue  <= pixel_q[0].blue;
            sample_alpha <= pixel_q[0].alpha;
            row_end      <= pixel_q[0].row_end;
        end
        else
            push <= 1'b0;
    end

    // byte receiver with random idling and an optional long hold-off
    always @(negedge clk)
    begin
        if (rx_stall_req > 0)
        begin
            rx_stall_left = rx_stall_req;
            rx_stall_req  = 0;
        end
        if (rx_stall_left > 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_format(input fmt_t f);
        write_reg(CFG_OUT_BITCOUNT, f.bitcount);
        write_reg(CFG_SOURCE_BITS, f.src_bits);
        write_reg(CFG_GRAY_SOURCE, f.gray);
        write_reg(CFG_RED_BITS, f.red);
        write_reg(CFG_GREEN_BITS, f.green);
        write_reg(CFG_BLUE_BITS, f.blue);
        write_reg(CFG_ALPHA_BITS, f.alpha);
        write_reg(CFG_ROW_PADDING, f.pad);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every pending pixel and expected byte, then let silent pixels clear
    task automatic drain();
        while (pixel_q.size() != 0 || expected_bytes_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
    endtask

    function automatic fmt_t make_format(logic [7:0] bc, logic [7:0] sb, logic [7:0] gray,
                                         logic [7:0] rb, logic [7:0] gb, logic [7:0] bb,
                                         logic [7:0] ab, logic [7:0] pad);
        return '{bc, sb, gray, rb, gb, bb, ab, pad};
    endfunction

    function automatic void add_pixel(logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
                                      logic [31:0] s3, logic re);
        pixel_q.push_back('{s0, s1, s2, s3, re});
    endfunction

    function automatic logic [31:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] random_width();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(1, 12));
    endfunction

    function automatic fmt_t random_format();
        fmt_t f;
        case ($urandom_range(0, 8))
            0:       f.bitcount = 8'd1;
            1:       f.bitcount = 8'd2;
            2:       f.bitcount = 8'd4;
            3:       f.bitcount = 8'd8;
            4:       f.bitcount = 8'd16;
            5:       f.bitcount = 8'd24;
            6:       f.bitcount = 8'd32;
            7:       f.bitcount = 8'($urandom_range(0, 63));
            default: f.bitcount = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 4))
            0:       f.src_bits = 8'd8;
            1:       f.src_bits = 8'd16;
            2:       f.src_bits = 8'd32;
            3:       f.src_bits = 8'($urandom_range(0, 63));
            default: f.src_bits = 8'($urandom_range(0, 255));
        endcase
        f.gray  = {7'($urandom_range(0, 127)), 1'($urandom_range(0, 3) == 0)};
        f.red   = random_width();
        f.green = random_width();
        f.blue  = random_width();
        f.alpha = ($urandom_range(0, 1) == 0) ? 8'd0 : random_width();
        f.pad   = 8'($urandom_range(0, 255));
        return f;
    endfunction

    // rows of random length, with the odd misplaced row end
    function automatic void queue_rows(int count, bit idx_mode);
        int pos, row_len;
        bit re;
        pos = 0;
        row_len = idx_mode ? $urandom_range(1, 20) : $urandom_range(1, 6);
        for (int k = 0; k < count; k++)
        begin
            re = (pos == row_len - 1);
            if ($urandom_range(0, 19) == 0)
                re = !re;
            add_pixel(random_sample(), random_sample(), random_sample(), random_sample(), re);
            pos++;
            if (pos == row_len)
            begin
                pos = 0;
                row_len = idx_mode ? $urandom_range(1, 20) : $urandom_range(1, 6);
            end
        end
    endfunction

    // stimulus sequence
    initial
    begin
        fmt_t f;
        int   n_rand, len, cut;
        bit   pressure, stall_done, idx_mode;
        stall_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct = 22;
        rx_idle_pct = 76;

        // formats straight out of reset
        add_pixel(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        add_pixel('1, '1, '1, '1, 1'b1);
        add_pixel(32'h12345678, 32'h9abcdef0, 32'h0f1e2d3c, 32'h4b5a6978, 1'b1);
        drain();

        // spare index ignored; 32 bpp with alpha and full padding
        write_reg(CFG_SPARE_IDX, 8'hff);
        load_format(make_format(8'd32, 8'd8, 8'd0, 8'd8, 8'd8, 8'd8, 8'd8, 8'd3));
        add_pixel('1, '1, '1, '1, 1'b1);
        add_pixel(32'ha5a5a5a5, 32'h5a5a5a5a, 32'hc3c3c3c3, 32'h3c3c3c3c, 1'b0);
        drain();

        // upper data bits dropped, widths over 32 clamped, fields past bit 31 lost
        load_format(make_format(8'he0, 8'd63, 8'hfe, 8'd40, 8'd5, 8'd6, 8'd33, 8'd1));
        add_pixel('1, 32'h80000000, 32'h7fffffff, 32'h00000001, 1'b1);
        drain();

        // zero source width gives zero samples, grey copy
        load_format(make_format(8'd24, 8'd0, 8'd1, 8'd8, 8'd8, 8'd8, 8'd4, 8'd2));
        add_pixel('1, '1, '1, '1, 1'b1);
        drain();

        // narrow source repeated up into wide fields
        load_format(make_format(8'd32, 8'd3, 8'd1, 8'd13, 8'd11, 8'd8, 8'd0, 8'd0));
        add_pixel(32'd5, 32'd0, 32'd0, 32'd0, 1'b0);
        add_pixel('1, 32'd0, 32'd0, 32'd0, 1'b1);
        drain();

        // bitcount below one byte gives padding only, above 32 gives four bytes
        load_format(make_format(8'd7, 8'd8, 8'd0, 8'd8, 8'd8, 8'd8, 8'd0, 8'd2));
        add_pixel($urandom, $urandom, $urandom, $urandom, 1'b1);
        add_pixel($urandom, $urandom, $urandom, $urandom, 1'b0);
        drain();
        load_format(make_format(8'd40, 8'd16, 8'd0, 8'd10, 8'd10, 8'd10, 8'd2, 8'd0));
        add_pixel($urandom, $urandom, $urandom, $urandom, 1'b1);
        drain();

        // 1 bpp row, upper index bits dropped, partial byte flushed at row end
        load_format(make_format(8'd1, 8'd8, 8'd0, 8'd8, 8'd8, 8'd8, 8'd0, 8'd1));
        for (int k = 0; k < 6; k++)
            add_pixel((k % 2) ? '1 : 32'hfffffffe, 32'd0, 32'd0, 32'd0, k == 5);
        drain();

        // index width grows mid-byte, then a direct pixel drops the partial byte
        load_format(make_format(8'd2, 8'd8, 8'd0, 8'd8, 8'd8, 8'd8, 8'd0, 8'd0));
        add_pixel(32'd1, 32'd0, 32'd0, 32'd0, 1'b0);
        add_pixel(32'd2, 32'd0, 32'd0, 32'd0, 1'b0);
        add_pixel(32'd3, 32'd0, 32'd0, 32'd0, 1'b0);
        drain();
        load_format(make_format(8'd8, 8'd8, 8'd0, 8'd8, 8'd8, 8'd8, 8'd0, 8'd0));
        add_pixel(32'h123456a7, 32'd0, 32'd0, 32'd0, 1'b0);
        drain();
        load_format(make_format(8'd4, 8'd8, 8'd0, 8'd8, 8'd8, 8'd8, 8'd0, 8'd0));
        add_pixel(32'hfffffff9, 32'd0, 32'd0, 32'd0, 1'b0);
        drain();
        load_format(make_format(8'd16, 8'd8, 8'd0, 8'd5, 8'd6, 8'd5, 8'd0, 8'd1));
        add_pixel($urandom, $urandom, $urandom, $urandom, 1'b1);
        drain();

        // random formats, each with a batch of rows
        n_rand = 0;
        while (n_rand < RAND_ITEMS)
        begin
            if (n_rand >= 2 * RAND_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (n_rand >= RAND_ITEMS / 3)
            begin
                tx_idle_pct = 76;
                rx_idle_pct = 22;
            end
            f = random_format();
            pressure = (tx_idle_pct == 0) && !stall_done;
            if (pressure)
                f.bitcount = 8'd32;
            load_format(f);
            idx_mode = is_indexed(f.bitcount[5:0]);
            len = pressure ? 22 : $urandom_range(10, 22);
            cut = (pressure || $urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : 0;
            // sender pause until all bytes so far have come out
            if (cut != 0)
            begin
                queue_rows(cut, idx_mode);
                drain();
            end
            // receiver holds off while the sender keeps offering, so the block fills
            if (pressure)
            begin
                rx_stall_req = STALL_CYCLES;
                stall_done = 1'b1;
            end
            queue_rows(len - cut, idx_mode);
            drain();
            n_rand += len;
        end

        if (mismatch_count == 0 && expected_bytes_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
